### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-consequence and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VMC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VMC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define VMC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg
// Shared types and constants of the vector magnitude clamp pipeline.
// ----------------------------------------------------------------------------
package vmc_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;
   localparam logic [30:0] TARGET_RESET = 31'd65536;

   typedef enum logic {
      REG_CLAMP_MODE    = 1'b0,
      REG_TARGET_LENGTH = 1'b1
   } vmc_reg_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               scale;
   } vmc_item_type;

   typedef struct packed {
      vmc_item_type item;
      logic [62:0]  nx;
      logic [62:0]  ny;
   } vmc_carry_type;

endpackage

### sv/vector2_magnitude_clamp_unit.sv
// ----------------------------------------------------------------------------
// vector2_magnitude_clamp_unit
// Limits or sets the length of a signed Q16.16 2D vector.
// ----------------------------------------------------------------------------
// Accepts one vector per cycle and returns one result per vector, in order,
// after three input stages (magnitude, products, sum and decision), a
// 32-stage square root, a 33-stage divider and the output register. The
// root and divider pipelines set the latency. While a result waits under
// rsp_stall the whole pipeline holds and req_stall is raised.
// ----------------------------------------------------------------------------
module vector2_magnitude_clamp_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic               rsp_was_scaled,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import vmc_pkg::*;
`include "assert_macros.svh"

   function automatic logic [31:0] sat_comp(logic neg, logic sat, logic [31:0] q);
      logic [32:0] cap;
      logic [32:0] m;
      cap = neg ? 33'h080000000 : 33'h07FFFFFFF;
      m   = (sat || ({1'b0, q} > cap)) ? cap : {1'b0, q};
      return neg ? 32'(33'd0 - m) : m[31:0];
   endfunction

   logic        mode_ff;
   logic [30:0] target_ff;
   vmc_reg_type reg_sel;
   logic        advance;

   assign reg_sel    = vmc_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         target_ff <= TARGET_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_sel)
            REG_CLAMP_MODE:    mode_ff   <= csr_pwdata[0];
            REG_TARGET_LENGTH: target_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CLAMP_MODE:    csr_prdata = {31'd0, mode_ff};
         REG_TARGET_LENGTH: csr_prdata = {1'b0, target_ff};
         default:           csr_prdata = '0;
      endcase
   end

   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: magnitudes
   logic               s1_vld_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic [31:0]        s1_ax_ff, s1_ay_ff;
   // stage 2: products
   logic               s2_vld_ff;
   logic signed [31:0] s2_x_ff, s2_y_ff;
   logic [63:0]        s2_sqx_ff, s2_sqy_ff;
   logic [62:0]        s2_nx_ff, s2_ny_ff;
   logic [61:0]        s2_tt_ff;
   // stage 3: sum and decision
   logic               s3_vld_ff;
   logic [63:0]        s3_s_ff;
   vmc_carry_type      s3_car_ff;
   logic [63:0]        s3_s_in;

   assign s3_s_in = s2_sqx_ff + s2_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      if (advance) begin
         s1_x_ff  <= req_in_x;
         s1_y_ff  <= req_in_y;
         s1_ax_ff <= req_in_x[31] ? 32'(-req_in_x) : req_in_x;
         s1_ay_ff <= req_in_y[31] ? 32'(-req_in_y) : req_in_y;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_sqx_ff <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff <= s1_ay_ff * s1_ay_ff;
         s2_nx_ff  <= s1_ax_ff * target_ff;
         s2_ny_ff  <= s1_ay_ff * target_ff;
         s2_tt_ff  <= target_ff * target_ff;
         s3_s_ff              <= s3_s_in;
         s3_car_ff.item.x     <= s2_x_ff;
         s3_car_ff.item.y     <= s2_y_ff;
         s3_car_ff.item.scale <= mode_ff ? (s3_s_in != 64'd0)
                                         : (s3_s_in > {2'b00, s2_tt_ff});
         s3_car_ff.nx         <= s2_nx_ff;
         s3_car_ff.ny         <= s2_ny_ff;
      end
   end

   logic          sq_vld;
   logic [31:0]   sq_root;
   vmc_carry_type sq_car;

   vmc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_vld_ff),
      .in_s      (s3_s_ff),
      .in_carry  (s3_car_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_carry (sq_car)
   );

   logic             dv_vld;
   vmc_item_type     dv_item;
   logic [1:0][31:0] dv_q;
   logic [1:0]       dv_sat;

   vmc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_vld),
      .in_div    (sq_root),
      .in_item   (sq_car.item),
      .in_num    ({sq_car.ny, sq_car.nx}),
      .out_valid (dv_vld),
      .out_item  (dv_item),
      .out_q     (dv_q),
      .out_sat   (dv_sat)
   );

   logic signed [31:0] out_x_ff, out_y_ff;
   logic               scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_vld;
      end
      if (advance) begin
         scaled_ff <= dv_item.scale;
         if (dv_item.scale) begin
            out_x_ff <= sat_comp(dv_item.x[31], dv_sat[0], dv_q[0]);
            out_y_ff <= sat_comp(dv_item.y[31], dv_sat[1], dv_q[1]);
         end else begin
            out_x_ff <= dv_item.x;
            out_y_ff <= dv_item.y;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_was_scaled = scaled_ff;

   `VMC_ASSERT_IMPL(a_root_nonzero, clock, reset, sq_vld && sq_car.item.scale, sq_root != 32'd0)
   `VMC_ASSERT_IMPL(a_limit_root, clock, reset, sq_vld && sq_car.item.scale && !mode_ff, sq_root >= {1'b0, target_ff})
   `VMC_ASSERT_NEXT(a_hold_root, clock, reset, sq_vld && req_stall, $stable(sq_root) && sq_vld)

endmodule

### sv/vmc_sqrt.sv
// ----------------------------------------------------------------------------
// vmc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vmc_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [63:0]           in_s,
   input  vmc_pkg::vmc_carry_type in_carry,
   output logic                  out_valid,
   output logic [31:0]           out_root,
   output vmc_pkg::vmc_carry_type out_carry
);
   import vmc_pkg::*;

   logic          vld_ff  [SQRT_STEPS];
   logic [63:0]   rem_ff  [SQRT_STEPS];
   logic [63:0]   root_ff [SQRT_STEPS];
   vmc_carry_type car_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
      logic          vld_pre;
      logic [63:0]   rem_pre;
      logic [63:0]   root_pre;
      vmc_carry_type car_pre;
      logic [63:0]   trial;
      logic [63:0]   rem_in;
      logic [63:0]   root_in;

      if (k == 0) begin : g_first
         assign vld_pre  = in_valid;
         assign rem_pre  = in_s;
         assign root_pre = '0;
         assign car_pre  = in_carry;
      end else begin : g_next
         assign vld_pre  = vld_ff[k-1];
         assign rem_pre  = rem_ff[k-1];
         assign root_pre = root_ff[k-1];
         assign car_pre  = car_ff[k-1];
      end

      always_comb begin
         trial = root_pre + BIT;
         if (rem_pre >= trial) begin
            rem_in  = rem_pre - trial;
            root_in = (root_pre >> 1) + BIT;
         end else begin
            rem_in  = rem_pre;
            root_in = root_pre >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_pre;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            car_ff[k]  <= car_pre;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1][31:0];
   assign out_carry = car_ff[SQRT_STEPS-1];

endmodule

### sv/vmc_div.sv
// ----------------------------------------------------------------------------
// vmc_div
// Two-lane pipelined restoring divider with quotient overflow detection.
// ----------------------------------------------------------------------------
module vmc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [31:0]           in_div,
   input  vmc_pkg::vmc_item_type in_item,
   input  logic [1:0][62:0]      in_num,
   output logic                  out_valid,
   output vmc_pkg::vmc_item_type out_item,
   output logic [1:0][31:0]      out_q,
   output logic [1:0]            out_sat
);
   import vmc_pkg::*;

   logic             ld_vld_ff;
   logic [31:0]      ld_div_ff;
   vmc_item_type     ld_item_ff;
   logic [1:0][31:0] ld_num_ff;
   logic [1:0][31:0] ld_rem_ff;
   logic [1:0]       ld_sat_ff;

   logic             vld_ff  [DIV_STEPS];
   logic [31:0]      div_ff  [DIV_STEPS];
   vmc_item_type     item_ff [DIV_STEPS];
   logic [1:0][31:0] num_ff  [DIV_STEPS];
   logic [1:0][31:0] rem_ff  [DIV_STEPS];
   logic [1:0][31:0] q_ff    [DIV_STEPS];
   logic [1:0]       sat_ff  [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_vld_ff <= 1'b0;
      end else if (advance) begin
         ld_vld_ff <= in_valid;
      end
      if (advance) begin
         ld_div_ff  <= in_div;
         ld_item_ff <= in_item;
         for (int i = 0; i < 2; i++) begin
            ld_num_ff[i] <= in_num[i][31:0];
            ld_rem_ff[i] <= {1'b0, in_num[i][62:32]};
            ld_sat_ff[i] <= {1'b0, in_num[i][62:32]} >= in_div;
         end
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic             vld_pre;
      logic [31:0]      div_pre;
      vmc_item_type     item_pre;
      logic [1:0][31:0] num_pre;
      logic [1:0][31:0] rem_pre;
      logic [1:0][31:0] q_pre;
      logic [1:0]       sat_pre;
      logic [1:0][31:0] rem_in;
      logic [1:0][31:0] q_in;

      if (j == 0) begin : g_first
         assign vld_pre  = ld_vld_ff;
         assign div_pre  = ld_div_ff;
         assign item_pre = ld_item_ff;
         assign num_pre  = ld_num_ff;
         assign rem_pre  = ld_rem_ff;
         assign q_pre    = '0;
         assign sat_pre  = ld_sat_ff;
      end else begin : g_next
         assign vld_pre  = vld_ff[j-1];
         assign div_pre  = div_ff[j-1];
         assign item_pre = item_ff[j-1];
         assign num_pre  = num_ff[j-1];
         assign rem_pre  = rem_ff[j-1];
         assign q_pre    = q_ff[j-1];
         assign sat_pre  = sat_ff[j-1];
      end

      always_comb begin
         logic [32:0] r;
         for (int i = 0; i < 2; i++) begin
            r = {rem_pre[i], num_pre[i][DIV_STEPS-1-j]};
            if (r >= {1'b0, div_pre}) begin
               rem_in[i] = 32'(r - {1'b0, div_pre});
               q_in[i]   = {q_pre[i][30:0], 1'b1};
            end else begin
               rem_in[i] = r[31:0];
               q_in[i]   = {q_pre[i][30:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (advance) begin
            vld_ff[j] <= vld_pre;
         end
         if (advance) begin
            div_ff[j]  <= div_pre;
            item_ff[j] <= item_pre;
            num_ff[j]  <= num_pre;
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            sat_ff[j]  <= sat_pre;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_item  = item_ff[DIV_STEPS-1];
   assign out_q     = q_ff[DIV_STEPS-1];
   assign out_sat   = sat_ff[DIV_STEPS-1];

endmodule
